>>> hdl/mrrc_pkg.sv
`default_nettype none

package mrrc_pkg;

  localparam int unsigned MAX_FRAME = 260;
  localparam int unsigned CNT_W     = 9;

  localparam logic [15:0] CRC_SEED   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam logic [7:0]  FC_HOLDING = 8'h03;
  localparam logic [7:0]  FC_INPUT   = 8'h04;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_BYTE  = 2'd1,
    OP_END   = 2'd2
  } opcode_t;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK     = 2'd0;
  localparam status_t ST_SHORT  = 2'd1;
  localparam status_t ST_HEADER = 2'd2;
  localparam status_t ST_CRC    = 2'd3;

  localparam logic KIND_WORD   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hdl/modbus_rtu_response_checker_core.sv
// An accepted beat is held in stage 1; any result it yields is then registered in the output stage.
// Throughput: one input beat per cycle while in_stall is low; the CRC of a byte is resolved in one pass.
// A beat with no result advances even while a finished result waits to be taken.
// Reset (rst_n low, synchronous): both stages empty, frame state cleared, CRC set to 0xFFFF.
`default_nettype none

module modbus_rtu_response_checker_core
  import mrrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_opcode,
  input  wire logic [7:0]  in_slave_address,
  input  wire logic [7:0]  in_function_code,
  input  wire logic [6:0]  in_register_count,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [15:0]      out_word_value,
  output logic [6:0]       out_word_index,
  output logic [1:0]       out_status
);

  logic             s1_valid_r, s1_valid_nxt;
  logic [1:0]       s1_opcode_r;
  logic [7:0]       s1_slave_r;
  logic [7:0]       s1_function_r;
  logic [6:0]       s1_count_r;
  logic [7:0]       s1_byte_r;

  logic [7:0]       exp_slave_r, exp_slave_nxt;
  logic [7:0]       exp_function_r, exp_function_nxt;
  logic [6:0]       exp_count_r, exp_count_nxt;
  logic [CNT_W-1:0] byte_counter_r, byte_counter_nxt;
  logic [15:0]      running_crc_r, running_crc_nxt;
  logic             header_bad_r, header_bad_nxt;
  logic             crc_bad_r, crc_bad_nxt;
  logic [7:0]       high_byte_hold_r, high_byte_hold_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_kind_r, out_kind_nxt;
  logic [15:0]      out_value_r, out_value_nxt;
  logic [6:0]       out_index_r, out_index_nxt;
  status_t          out_status_r, out_status_nxt;

  logic             in_accept;
  logic             s1_res;
  logic             s1_adv;
  logic [CNT_W-1:0] expected;
  logic [CNT_W-1:0] data_end;
  logic [CNT_W-1:0] pos_off;

  assign expected = CNT_W'(5) + {1'b0, exp_count_r, 1'b0};
  assign data_end = CNT_W'(3) + {1'b0, exp_count_r, 1'b0};
  assign pos_off  = byte_counter_r - CNT_W'(3);

  always_comb begin
    s1_res             = 1'b0;
    exp_slave_nxt      = exp_slave_r;
    exp_function_nxt   = exp_function_r;
    exp_count_nxt      = exp_count_r;
    byte_counter_nxt   = byte_counter_r;
    running_crc_nxt    = running_crc_r;
    header_bad_nxt     = header_bad_r;
    crc_bad_nxt        = crc_bad_r;
    high_byte_hold_nxt = high_byte_hold_r;
    out_kind_nxt       = KIND_WORD;
    out_value_nxt      = 16'h0000;
    out_index_nxt      = 7'd0;
    out_status_nxt     = ST_OK;
    unique case (opcode_t'(s1_opcode_r))
      OP_BEGIN: begin
        exp_slave_nxt      = s1_slave_r;
        exp_function_nxt   = s1_function_r;
        exp_count_nxt      = s1_count_r;
        byte_counter_nxt   = '0;
        running_crc_nxt    = CRC_SEED;
        header_bad_nxt     = 1'b0;
        crc_bad_nxt        = 1'b0;
        high_byte_hold_nxt = 8'h00;
      end
      OP_BYTE: begin
        if (byte_counter_r < expected && byte_counter_r < CNT_W'(MAX_FRAME)) begin
          if (byte_counter_r == CNT_W'(0)) begin
            if (s1_byte_r != exp_slave_r) header_bad_nxt = 1'b1;
          end else if (byte_counter_r == CNT_W'(1)) begin
            if (s1_byte_r != exp_function_r ||
                (exp_function_r != FC_HOLDING && exp_function_r != FC_INPUT))
              header_bad_nxt = 1'b1;
          end else if (byte_counter_r == CNT_W'(2)) begin
            if (s1_byte_r != {exp_count_r, 1'b0}) header_bad_nxt = 1'b1;
          end else if (byte_counter_r < data_end) begin
            if (!pos_off[0]) begin
              high_byte_hold_nxt = s1_byte_r;
            end else begin
              s1_res        = 1'b1;
              out_value_nxt = {high_byte_hold_r, s1_byte_r};
              out_index_nxt = pos_off[7:1];
            end
          end else if (byte_counter_r == data_end) begin
            if (s1_byte_r != running_crc_r[7:0]) crc_bad_nxt = 1'b1;
          end else begin
            if (s1_byte_r != running_crc_r[15:8]) crc_bad_nxt = 1'b1;
          end
          if (byte_counter_r < data_end)
            running_crc_nxt = crc16_byte(running_crc_r, s1_byte_r);
          byte_counter_nxt = byte_counter_r + CNT_W'(1);
        end
      end
      OP_END: begin
        s1_res       = 1'b1;
        out_kind_nxt = KIND_STATUS;
        if (byte_counter_r < expected)
          out_status_nxt = ST_SHORT;
        else if (header_bad_r)
          out_status_nxt = ST_HEADER;
        else if (crc_bad_r)
          out_status_nxt = ST_CRC;
        else
          out_status_nxt = ST_OK;
      end
      default: begin
      end
    endcase
  end

  // advance unless a result needs a slot that is still held
  assign s1_adv        = s1_valid_r && (!s1_res || !out_valid_r || !out_stall);
  assign in_stall      = s1_valid_r && !s1_adv;
  assign in_accept     = in_valid && !in_stall;
  assign s1_valid_nxt  = in_accept || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = (s1_adv && s1_res) || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
      exp_slave_r      <= 8'h00;
      exp_function_r   <= 8'h00;
      exp_count_r      <= 7'd0;
      byte_counter_r   <= '0;
      running_crc_r    <= CRC_SEED;
      header_bad_r     <= 1'b0;
      crc_bad_r        <= 1'b0;
      high_byte_hold_r <= 8'h00;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv) begin
        exp_slave_r      <= exp_slave_nxt;
        exp_function_r   <= exp_function_nxt;
        exp_count_r      <= exp_count_nxt;
        byte_counter_r   <= byte_counter_nxt;
        running_crc_r    <= running_crc_nxt;
        header_bad_r     <= header_bad_nxt;
        crc_bad_r        <= crc_bad_nxt;
        high_byte_hold_r <= high_byte_hold_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_opcode_r   <= in_opcode;
      s1_slave_r    <= in_slave_address;
      s1_function_r <= in_function_code;
      s1_count_r    <= in_register_count;
      s1_byte_r     <= in_rx_byte;
    end
    if (s1_adv && s1_res) begin
      out_kind_r   <= out_kind_nxt;
      out_value_r  <= out_value_nxt;
      out_index_r  <= out_index_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_word_value  = out_value_r;
  assign out_word_index  = out_index_r;
  assign out_status      = out_status_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    byte_counter_r <= expected)
    else $error("byte counter beyond expected frame length");

  a_stall_needs_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_res && out_valid_r)
    else $error("input stalled without a blocked result");

  a_header_after_byte: assert property (@(posedge clk) disable iff (!rst_n)
    header_bad_r |-> byte_counter_r != CNT_W'(0))
    else $error("header mismatch flagged before any byte");

  a_crc_after_data: assert property (@(posedge clk) disable iff (!rst_n)
    crc_bad_r |-> byte_counter_r > data_end)
    else $error("crc mismatch flagged before crc bytes");

  a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_res |=> out_valid_r)
    else $error("advanced result not held in output register");
`endif

endmodule

`default_nettype wire
